[hdl/pcw_pkg.sv]
// Shared widths, sector codes and palette for the color wheel pixel unit.
package pcw_pkg;

  localparam int COORD_BITS   = 9;
  localparam int SQR_W        = 2 * COORD_BITS;
  localparam int RAD_W        = 2 * COORD_BITS + 16;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int FRONT_STAGES = 4;
  localparam int LATENCY      = FRONT_STAGES + ROOT_W + 1;

  localparam logic [15:0] FULL_SQ = 16'd65025;

  typedef enum logic [3:0] {
    SEC_RED        = 4'd0,
    SEC_ORANGE     = 4'd1,
    SEC_YELLOW     = 4'd2,
    SEC_CHARTREUSE = 4'd3,
    SEC_GREEN      = 4'd4,
    SEC_SPRING     = 4'd5,
    SEC_CYAN       = 4'd6,
    SEC_AZURE      = 4'd7,
    SEC_BLUE       = 4'd8,
    SEC_VIOLET     = 4'd9,
    SEC_MAGENTA    = 4'd10,
    SEC_ROSE       = 4'd11
  } sector_e;

  typedef enum logic [1:0] {
    LVL_ZERO,
    LVL_HALF,
    LVL_FULL
  } level_e;

  typedef struct packed {
    level_e r;
    level_e g;
    level_e b;
  } swatch_t;

  typedef struct packed {
    logic    valid;
    sector_e sector;
  } tag_t;

  function automatic swatch_t palette(sector_e s);
    swatch_t p;
    case (s)
      SEC_RED:        p = '{LVL_FULL, LVL_ZERO, LVL_ZERO};
      SEC_ORANGE:     p = '{LVL_FULL, LVL_HALF, LVL_ZERO};
      SEC_YELLOW:     p = '{LVL_FULL, LVL_FULL, LVL_ZERO};
      SEC_CHARTREUSE: p = '{LVL_HALF, LVL_FULL, LVL_ZERO};
      SEC_GREEN:      p = '{LVL_ZERO, LVL_FULL, LVL_ZERO};
      SEC_SPRING:     p = '{LVL_ZERO, LVL_FULL, LVL_HALF};
      SEC_CYAN:       p = '{LVL_ZERO, LVL_FULL, LVL_FULL};
      SEC_AZURE:      p = '{LVL_ZERO, LVL_HALF, LVL_FULL};
      SEC_BLUE:       p = '{LVL_ZERO, LVL_ZERO, LVL_FULL};
      SEC_VIOLET:     p = '{LVL_HALF, LVL_ZERO, LVL_FULL};
      SEC_MAGENTA:    p = '{LVL_FULL, LVL_ZERO, LVL_FULL};
      SEC_ROSE:       p = '{LVL_FULL, LVL_ZERO, LVL_HALF};
      default:        p = '{LVL_ZERO, LVL_ZERO, LVL_ZERO};
    endcase
    return p;
  endfunction

endpackage

[hdl/pcw_front.sv]
// Front stages: magnitudes, squares, radius squared, sector and scaled radicands.
module pcw_front (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [pcw_pkg::COORD_BITS-1:0]  x_coord_i,
  input  logic signed [pcw_pkg::COORD_BITS-1:0]  y_coord_i,
  output pcw_pkg::tag_t                          tag_o,
  output logic        [pcw_pkg::RAD_W-1:0]       rad_full_o,
  output logic        [pcw_pkg::RAD_W-1:0]       rad_half_o
);

  localparam int W  = pcw_pkg::COORD_BITS;
  localparam int SW = pcw_pkg::SQR_W;
  localparam int RW = pcw_pkg::RAD_W;

  // stage 1
  logic          v1_q;
  logic [W-1:0]  ax_q, ay_q;
  logic          xneg1_q, yneg1_q, xz1_q, yz1_q;
  logic [W-1:0]  ax_d, ay_d;

  // stage 2
  logic          v2_q;
  logic [SW-1:0] x2_q, y2_q;
  logic          xneg2_q, yneg2_q, xz2_q, yz2_q;
  logic [SW-1:0] ax_w, ay_w, x2_d, y2_d;

  // stage 3
  logic              v3_q;
  logic [SW-1:0]     r2_q;
  pcw_pkg::sector_e  sec3_q;
  logic [SW-1:0]     r2_d;
  logic [SW+1:0]     x2_e, y2_e, x3_e, y3_e;
  logic [1:0]        k;
  pcw_pkg::sector_e  sec3_d;

  // stage 4
  logic              v4_q;
  logic [RW-1:0]     full_q, half_q;
  pcw_pkg::sector_e  sec4_q;
  logic [RW-1:0]     r2_w, full_d, half_d;

  assign ax_d = x_coord_i[W-1] ? (~x_coord_i + 1'b1) : x_coord_i;
  assign ay_d = y_coord_i[W-1] ? (~y_coord_i + 1'b1) : y_coord_i;

  assign ax_w = {{(SW-W){1'b0}}, ax_q};
  assign ay_w = {{(SW-W){1'b0}}, ay_q};
  assign x2_d = ax_w * ax_w;
  assign y2_d = ay_w * ay_w;

  assign r2_d = x2_q + y2_q;
  assign x2_e = {2'b00, x2_q};
  assign y2_e = {2'b00, y2_q};
  assign x3_e = {x2_e[SW:0], 1'b0} + x2_e;
  assign y3_e = {y2_e[SW:0], 1'b0} + y2_e;

  always_comb begin
    if (y3_e < x2_e) begin
      k = 2'd0;
    end else if (y2_e < x3_e) begin
      k = 2'd1;
    end else begin
      k = 2'd2;
    end
    if (yz2_q) begin
      sec3_d = pcw_pkg::SEC_RED;
    end else if (xz2_q) begin
      sec3_d = yneg2_q ? pcw_pkg::SEC_VIOLET : pcw_pkg::SEC_YELLOW;
    end else if (!xneg2_q && !yneg2_q) begin
      sec3_d = pcw_pkg::sector_e'({2'b00, k});
    end else if (xneg2_q && !yneg2_q) begin
      sec3_d = pcw_pkg::sector_e'(4'd5 - {2'b00, k});
    end else if (xneg2_q) begin
      sec3_d = pcw_pkg::sector_e'(4'd6 + {2'b00, k});
    end else begin
      sec3_d = pcw_pkg::sector_e'(4'd11 - {2'b00, k});
    end
  end

  assign r2_w   = {{(RW-SW){1'b0}}, r2_q};
  assign full_d = r2_w * {{(RW-16){1'b0}}, pcw_pkg::FULL_SQ};
  assign half_d = r2_w >> 2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    xneg1_q <= x_coord_i[W-1];
    yneg1_q <= y_coord_i[W-1];
    xz1_q   <= (x_coord_i == '0);
    yz1_q   <= (y_coord_i == '0);

    x2_q    <= x2_d;
    y2_q    <= y2_d;
    xneg2_q <= xneg1_q;
    yneg2_q <= yneg1_q;
    xz2_q   <= xz1_q;
    yz2_q   <= yz1_q;

    r2_q    <= r2_d;
    sec3_q  <= sec3_d;

    full_q  <= full_d;
    half_q  <= half_d;
    sec4_q  <= sec3_q;
  end

  assign tag_o.valid  = v4_q;
  assign tag_o.sector = sec4_q;
  assign rad_full_o   = full_q;
  assign rad_half_o   = half_q;

endmodule

[hdl/pcw_sqrt.sv]
// Two-lane pipelined integer square root, one root bit per stage.
module pcw_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcw_pkg::tag_t                   tag_i,
  input  logic [pcw_pkg::RAD_W-1:0]       rad_full_i,
  input  logic [pcw_pkg::RAD_W-1:0]       rad_half_i,
  output pcw_pkg::tag_t                   tag_o,
  output logic [pcw_pkg::ROOT_W-1:0]      root_full_o,
  output logic [pcw_pkg::ROOT_W-1:0]      root_half_o
);

  localparam int RW = pcw_pkg::RAD_W;
  localparam int N  = pcw_pkg::ROOT_W;
  localparam int MW = pcw_pkg::REM_W;

  logic             valid_q  [N];
  pcw_pkg::sector_e sector_q [N];
  logic [RW-1:0]    op_q     [2][N];
  logic [MW-1:0]    rem_q    [2][N];
  logic [N-1:0]     root_q   [2][N];

  logic [RW-1:0]    op_in    [2][N];
  logic [MW-1:0]    rem_in   [2][N];
  logic [N-1:0]     root_in  [2][N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign op_in[0][0]   = rad_full_i;
      assign op_in[1][0]   = rad_half_i;
      assign rem_in[0][0]  = '0;
      assign rem_in[1][0]  = '0;
      assign root_in[0][0] = '0;
      assign root_in[1][0] = '0;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[0] <= 1'b0;
        end else begin
          valid_q[0] <= tag_i.valid;
        end
      end
      always_ff @(posedge clk_i) begin
        sector_q[0] <= tag_i.sector;
      end
    end else begin : g_rest
      for (genvar l = 0; l < 2; l++) begin : g_link
        assign op_in[l][s]   = op_q[l][s-1];
        assign rem_in[l][s]  = rem_q[l][s-1];
        assign root_in[l][s] = root_q[l][s-1];
      end
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        sector_q[s] <= sector_q[s-1];
      end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [MW-1:0] rem_sh, trial;
      logic [MW-1:0] rem_d;
      logic [N-1:0]  root_d;

      assign rem_sh = {rem_in[l][s][MW-3:0], op_in[l][s][RW-1 -: 2]};
      assign trial  = {root_in[l][s], 2'b01};

      always_comb begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_in[l][s][N-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_in[l][s][N-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk_i) begin
        op_q[l][s]   <= {op_in[l][s][RW-3:0], 2'b00};
        rem_q[l][s]  <= rem_d;
        root_q[l][s] <= root_d;
      end
    end
  end

  assign tag_o.valid  = valid_q[N-1];
  assign tag_o.sector = sector_q[N-1];
  assign root_full_o  = root_q[0][N-1];
  assign root_half_o  = root_q[1][N-1];

endmodule

[hdl/pcw_out.sv]
// Output stage: palette level select, saturation and result register.
module pcw_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcw_pkg::tag_t               tag_i,
  input  logic [pcw_pkg::ROOT_W-1:0]  root_full_i,
  input  logic [pcw_pkg::ROOT_W-1:0]  root_half_i,
  output logic                        valid_o,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o,
  output logic [3:0]                  hue_sector_o
);

  localparam int N = pcw_pkg::ROOT_W;

  logic             valid_q;
  logic [7:0]       red_q, green_q, blue_q;
  pcw_pkg::sector_e sec_q;
  pcw_pkg::swatch_t sw;
  logic [7:0]       full_sat, half_sat;
  logic [N-1:0]     full_scaled;

  function automatic logic [7:0] pick(pcw_pkg::level_e lv, logic [7:0] f, logic [7:0] h);
    logic [7:0] v;
    case (lv)
      pcw_pkg::LVL_FULL: v = f;
      pcw_pkg::LVL_HALF: v = h;
      default:           v = 8'd0;
    endcase
    return v;
  endfunction

  assign sw          = pcw_pkg::palette(tag_i.sector);
  assign full_scaled = root_full_i >> 8;
  assign full_sat    = (full_scaled > N'(255)) ? 8'd255 : full_scaled[7:0];
  assign half_sat    = (root_half_i > N'(255)) ? 8'd255 : root_half_i[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tag_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= pick(sw.r, full_sat, half_sat);
    green_q <= pick(sw.g, full_sat, half_sat);
    blue_q  <= pick(sw.b, full_sat, half_sat);
    sec_q   <= tag_i.sector;
  end

  assign valid_o      = valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign hue_sector_o = sec_q;

endmodule

[hdl/polar_color_wheel_pixel_unit.sv]
// Top level of the twelve-sector color wheel pixel unit.
// A pixel offset is taken on every cycle that start is high; busy never rises, so one
// coordinate per clock is sustained. Each result appears on the result ports for one
// cycle with valid_o high, after its start has passed through 4 front stages, one stage
// per root bit of the square-root pipeline, COORD_BITS+8 stages, and one output
// register. The receiver cannot stall.
module polar_color_wheel_pixel_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [pcw_pkg::COORD_BITS-1:0]  x_coord_i,
  input  logic signed [pcw_pkg::COORD_BITS-1:0]  y_coord_i,
  output logic                                   valid_o,
  output logic        [7:0]                      red_o,
  output logic        [7:0]                      green_o,
  output logic        [7:0]                      blue_o,
  output logic        [3:0]                      hue_sector_o
);

  pcw_pkg::tag_t                  front_tag, sqrt_tag;
  logic [pcw_pkg::RAD_W-1:0]      rad_full, rad_half;
  logic [pcw_pkg::ROOT_W-1:0]     root_full, root_half;

  assign busy = 1'b0;

  pcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start && !busy),
    .x_coord_i  (x_coord_i),
    .y_coord_i  (y_coord_i),
    .tag_o      (front_tag),
    .rad_full_o (rad_full),
    .rad_half_o (rad_half)
  );

  pcw_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (front_tag),
    .rad_full_i  (rad_full),
    .rad_half_i  (rad_half),
    .tag_o       (sqrt_tag),
    .root_full_o (root_full),
    .root_half_o (root_half)
  );

  pcw_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (sqrt_tag),
    .root_full_i  (root_full),
    .root_half_i  (root_half),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .hue_sector_o (hue_sector_o)
  );

endmodule

[hdl/pcw_checker.sv]
// Port-level checks for the color wheel pixel unit, bound to the top level.
module pcw_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start,
  input logic                                   busy,
  input logic signed [pcw_pkg::COORD_BITS-1:0]  x_coord_i,
  input logic signed [pcw_pkg::COORD_BITS-1:0]  y_coord_i,
  input logic                                   valid_o,
  input logic        [7:0]                      red_o,
  input logic        [7:0]                      green_o,
  input logic        [7:0]                      blue_o,
  input logic        [3:0]                      hue_sector_o
);

  localparam int LAT = pcw_pkg::LATENCY;

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT valid_o)
    else $error("accepted beat did not produce a result at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted beat");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hue_sector_o <= pcw_pkg::SEC_ROSE))
    else $error("hue sector out of range");

  a_red_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && hue_sector_o == pcw_pkg::SEC_RED) |-> (green_o == 8'd0 && blue_o == 8'd0))
    else $error("red sector with nonzero green or blue");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && x_coord_i == '0 && y_coord_i == '0) |-> ##LAT
      (red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0 &&
       hue_sector_o == pcw_pkg::SEC_RED))
    else $error("origin beat did not give a black sector zero result");

endmodule

bind polar_color_wheel_pixel_unit pcw_checker u_pcw_checker (.*);

[verif/polar_color_wheel_pixel_unit_tb.sv]
// Testbench for the color wheel pixel unit: random and directed coordinates, scoreboard check.
module polar_color_wheel_pixel_unit_tb;

  typedef logic signed [pcw_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    pcw_pkg::sector_e hue;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t owed[$];
    int     errors = 0;

    function void note(pixel_t p);
      owed.push_back(p);
    endfunction

    function void check(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [3:0] h);
      pixel_t e;
      if (owed.size() == 0) begin
        $error("result beat with no pixel outstanding");
        errors++;
        return;
      end
      e = owed.pop_front();
      if (r !== e.red) begin
        $error("red expected %0d got %0d", e.red, r);
        errors++;
      end
      if (g !== e.green) begin
        $error("green expected %0d got %0d", e.green, g);
        errors++;
      end
      if (b !== e.blue) begin
        $error("blue expected %0d got %0d", e.blue, b);
        errors++;
      end
      if (h !== e.hue) begin
        $error("hue_sector expected %0d got %0d", e.hue, h);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start;
  logic       busy;
  coord_t     x_coord;
  coord_t     y_coord;
  logic       valid_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic [3:0] hue_sector_o;

  pixel_scoreboard wheel_sb;
  logic            beat_taken = 1'b0;
  int              idle_pct = 22;

  int unsigned wheel_rgb [12][3] = '{
    '{255, 0, 0},   '{255, 128, 0}, '{255, 255, 0},
    '{128, 255, 0}, '{0, 255, 0},   '{0, 255, 128},
    '{0, 255, 255}, '{0, 128, 255}, '{0, 0, 255},
    '{128, 0, 255}, '{255, 0, 255}, '{255, 0, 128}
  };

  polar_color_wheel_pixel_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .x_coord_i    (x_coord),
    .y_coord_i    (y_coord),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .hue_sector_o (hue_sector_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    longint unsigned rem;
    res   = 0;
    rem   = n;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= res + probe) begin
        rem -= res + probe;
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  function automatic pcw_pkg::sector_e wheel_sector(int x, int y);
    longint unsigned x2;
    longint unsigned y2;
    int              k;
    if (y == 0) return pcw_pkg::SEC_RED;
    if (x == 0) return (y > 0) ? pcw_pkg::SEC_YELLOW : pcw_pkg::SEC_VIOLET;
    x2 = x * x;
    y2 = y * y;
    if (3 * y2 < x2) k = 0;
    else if (y2 < 3 * x2) k = 1;
    else k = 2;
    if (x > 0 && y > 0) return pcw_pkg::sector_e'(k);
    if (x < 0 && y > 0) return pcw_pkg::sector_e'(5 - k);
    if (x < 0) return pcw_pkg::sector_e'(6 + k);
    return pcw_pkg::sector_e'(11 - k);
  endfunction

  function automatic pixel_t shade_pixel(coord_t xc, coord_t yc);
    pixel_t          p;
    int              x;
    int              y;
    longint unsigned r2;
    longint unsigned c;
    longint unsigned v;
    logic [7:0]      ch_val [3];
    x = int'(xc);
    y = int'(yc);
    r2 = x * x + y * y;
    p.hue = wheel_sector(x, y);
    for (int ch = 0; ch < 3; ch++) begin
      c = wheel_rgb[p.hue][ch];
      v = root_floor(c * c * r2) >> 8;
      ch_val[ch] = (v > 255) ? 8'd255 : v[7:0];
    end
    p.red   = ch_val[0];
    p.green = ch_val[1];
    p.blue  = ch_val[2];
    return p;
  endfunction

  always @(posedge clk_i) begin
    beat_taken = rst_ni && start && !busy;
    if (rst_ni) begin
      if (valid_o) wheel_sb.check(red_o, green_o, blue_o, hue_sector_o);
      if (beat_taken) wheel_sb.note(shade_pixel(x_coord, y_coord));
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_pixel(coord_t x, coord_t y);
    while ($urandom_range(99, 0) < idle_pct) begin
      start   = 1'b0;
      x_coord = coord_t'($urandom);
      y_coord = coord_t'($urandom);
      @(negedge clk_i);
    end
    start   = 1'b1;
    x_coord = x;
    y_coord = y;
    @(negedge clk_i);
    while (!beat_taken) @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    int x;
    int y;
    int ax;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 55) begin
      x = $urandom_range(511, 0) - 256;
      y = $urandom_range(511, 0) - 256;
    end else if (pick < 70) begin
      x = $urandom_range(15, 0) - 8;
      y = $urandom_range(15, 0) - 8;
    end else if (pick < 78) begin
      x = $urandom_range(511, 0) - 256;
      y = 0;
      if ($urandom_range(1, 0)) begin
        y = x;
        x = 0;
      end
    end else begin
      ax = $urandom_range(255, 2);
      if ($urandom_range(1, 0)) y = ax * 1000 / 1732 + $urandom_range(2, 0) - 1;
      else y = ax * 1732 / 1000 + $urandom_range(2, 0) - 1;
      if (y > 255) y = 255;
      x = ax;
      if ($urandom_range(1, 0)) x = -x;
      if ($urandom_range(1, 0)) y = -y;
    end
    send_pixel(coord_t'(x), coord_t'(y));
  endtask

  initial begin
    #200000;
    $display("FAIL polar_color_wheel_pixel_unit");
    $finish;
  end

  initial begin
    wheel_sb = new();
    rst_ni   = 1'b0;
    start    = 1'b0;
    x_coord  = '0;
    y_coord  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_pixel(0, 0);
    send_pixel(0, 5);
    send_pixel(0, -5);
    send_pixel(7, 0);
    send_pixel(-7, 0);
    send_pixel(0, 255);
    send_pixel(0, -256);
    send_pixel(-256, 0);
    send_pixel(255, 0);
    send_pixel(255, 255);
    send_pixel(-256, -256);
    send_pixel(-256, 255);
    send_pixel(255, -256);
    send_pixel(1, 1);
    send_pixel(-1, -1);
    send_pixel(97, 56);
    send_pixel(97, 57);
    send_pixel(56, 97);
    send_pixel(57, 97);
    send_pixel(-97, 56);
    send_pixel(-56, -97);
    send_pixel(97, -57);
    send_pixel(-97, -56);
    send_pixel(56, -97);

    for (int i = 0; i < 1400; i++) begin
      idle_pct = (i >= 500 && i < 800) ? 0 : 22;
      send_random_pixel();
    end
    start = 1'b0;

    while (wheel_sb.owed.size() != 0) @(negedge clk_i);
    repeat (pcw_pkg::LATENCY + 8) @(negedge clk_i);

    if (wheel_sb.errors == 0) $display("PASS polar_color_wheel_pixel_unit");
    else $display("FAIL polar_color_wheel_pixel_unit");
    $finish;
  end

endmodule

[polar_color_wheel_pixel_unit.f]
hdl/pcw_pkg.sv
hdl/pcw_front.sv
hdl/pcw_sqrt.sv
hdl/pcw_out.sv
hdl/polar_color_wheel_pixel_unit.sv
hdl/pcw_checker.sv
verif/polar_color_wheel_pixel_unit_tb.sv
